// ----- sv/slcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

    localparam int BUFFER_BYTES = 73;
    localparam int MAX_PAYLOAD  = 32;
    localparam int COUNT_BITS   = 16;
    localparam int MAX_EVENTS   = 64;
    localparam int KEEP_TAIL    = 3;
    localparam int HEADER_LEN   = 8;
    localparam int POS_W        = 7;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int EVCNT_W      = $clog2(MAX_EVENTS + 1);
    localparam int LIM_W        = 6;

    // largest length that still fits a whole frame in the buffer
    localparam int EFF_CAP = (MAX_PAYLOAD < BUFFER_BYTES - 9) ? MAX_PAYLOAD : BUFFER_BYTES - 9;

    localparam logic [7:0] STX_BYTE = 8'h02;

    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_GARBAGE  = 2'd1;
    localparam logic [1:0] EV_LENGTH   = 2'd2;
    localparam logic [1:0] EV_CHECKSUM = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            data;
        logic [COUNT_BITS-1:0] run;
    } ev_t;

    typedef struct packed {
        logic push;
        logic flush;
        ev_t  ev;
    } ostg_ctl_t;

    // ring-buffer address of logical position pos
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [POS_W-1:0] pos);
        logic [POS_W:0] sum;
        sum = {1'b0, POS_W'(head)} + {1'b0, pos};
        if (sum >= (POS_W+1)'(BUFFER_BYTES)) begin
            sum = sum - (POS_W+1)'(BUFFER_BYTES);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

`default_nettype wire

// ----- sv/slcd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 73
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/slcd_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slcd_out_stage import slcd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ostg_ctl_t             ctl,
    output logic                       room,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_event_kind,
    output logic [7:0]                 m_payload_byte,
    output logic                       m_last,
    output logic [COUNT_BITS-1:0]      m_error_run_count
);

    // one event is held back so the final one can carry last
    logic pend_valid_reg, pend_valid_next;
    ev_t  pend_reg, pend_next;
    logic out_valid_reg, out_valid_next;
    ev_t  out_reg, out_next;
    logic out_last_reg, out_last_next;

    assign room = !pend_valid_reg || !out_valid_reg || m_ready;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (ctl.push) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = ctl.ev;
        end else if (ctl.flush && pend_valid_reg) begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_event_kind      = out_reg.kind;
    assign m_payload_byte    = out_reg.data;
    assign m_last            = out_last_reg;
    assign m_error_run_count = out_reg.run;

endmodule

`default_nettype wire

// ----- sv/slcd_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slcd_scan import slcd_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_rx_byte,
    input  wire logic              s_end_of_chunk,
    input  wire logic              cfg_wr_en,
    input  wire logic [LIM_W-1:0]  cfg_wr_data,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic                   ram_re,
    output logic [ADDR_W-1:0]      ram_raddr,
    input  wire logic [7:0]        ram_q,
    input  wire logic              room,
    output ostg_ctl_t              octl
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOP  = 4'd1;
    localparam logic [3:0] S_FRD   = 4'd2;
    localparam logic [3:0] S_FDT   = 4'd3;
    localparam logic [3:0] S_NOTF  = 4'd4;
    localparam logic [3:0] S_FOUND = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_LDT   = 4'd7;
    localparam logic [3:0] S_LCHK  = 4'd8;
    localparam logic [3:0] S_CRD   = 4'd9;
    localparam logic [3:0] S_CDT   = 4'd10;
    localparam logic [3:0] S_CRES  = 4'd11;
    localparam logic [3:0] S_PRD   = 4'd12;
    localparam logic [3:0] S_PDT   = 4'd13;
    localparam logic [3:0] S_CMP   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    localparam logic [COUNT_BITS-1:0] RUN_MAX = '1;

    logic [3:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [POS_W-1:0]      fill_reg, fill_next;
    logic [POS_W-1:0]      charged_reg, charged_next;
    logic [COUNT_BITS-1:0] err_reg, err_next;
    logic [POS_W-1:0]      sp_reg, sp_next;
    logic [POS_W-1:0]      j_reg, j_next;
    logic [1:0]            run_reg, run_next;
    logic [POS_W-1:0]      stx_reg, stx_next;
    logic                  hinz_reg, hinz_next;
    logic [7:0]            lo_reg, lo_next;
    logic [POS_W-1:0]      endp_reg, endp_next;
    logic [7:0]            cs_reg, cs_next;
    logic                  csbad_reg, csbad_next;
    logic [EVCNT_W-1:0]    evcnt_reg, evcnt_next;
    logic [LIM_W-1:0]      cfg_reg;

    logic                  fire, is_err, emit_req, stall;
    logic [1:0]            ev_kind;
    logic [COUNT_BITS-1:0] err_inc;
    logic [POS_W-1:0]      from_pos, keep_pos, avail;
    logic [LIM_W-1:0]      lim;
    logic                  len_zero, len_bad;
    logic [POS_W-1:0]      len_end;
    logic                  accept;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign err_inc  = (err_reg == RUN_MAX) ? err_reg : err_reg + 1'b1;
    assign from_pos = (sp_reg > charged_reg) ? sp_reg : charged_reg;
    assign keep_pos = ((fill_reg - POS_W'(KEEP_TAIL)) > sp_reg) ?
                      (fill_reg - POS_W'(KEEP_TAIL)) : sp_reg;
    assign avail    = fill_reg - stx_reg;
    assign lim      = (cfg_reg > LIM_W'(EFF_CAP)) ? LIM_W'(EFF_CAP) : cfg_reg;
    assign len_zero = !hinz_reg && (lo_reg == 8'd0);
    assign len_bad  = hinz_reg || (lo_reg == 8'd0) || (lo_reg > {2'b00, lim});
    assign len_end  = stx_reg + POS_W'(HEADER_LEN) + {6'd0, len_zero};

    // event raised by the current state
    always_comb begin
        fire    = 1'b0;
        is_err  = 1'b1;
        ev_kind = EV_GARBAGE;
        unique case (state_reg)
            S_NOTF: begin
                fire = (fill_reg > POS_W'(KEEP_TAIL)) && (keep_pos > from_pos);
            end
            S_FOUND: begin
                fire = (stx_reg > from_pos);
            end
            S_LCHK: begin
                fire    = len_bad;
                ev_kind = EV_LENGTH;
            end
            S_CRES: begin
                fire    = csbad_reg;
                ev_kind = EV_CHECKSUM;
            end
            S_PDT: begin
                fire    = 1'b1;
                is_err  = 1'b0;
                ev_kind = EV_PAYLOAD;
            end
            default: begin
                fire = 1'b0;
            end
        endcase
    end

    assign emit_req = fire && (evcnt_reg < EVCNT_W'(MAX_EVENTS));
    assign stall    = emit_req && !room;

    always_comb begin
        octl.push    = emit_req && room;
        octl.flush   = (state_reg == S_DONE) && room;
        octl.ev.kind = ev_kind;
        octl.ev.data = is_err ? 8'd0 : ram_q;
        octl.ev.run  = is_err ? err_inc : '0;
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        charged_next = charged_reg;
        err_next     = err_reg;
        sp_next      = sp_reg;
        j_next       = j_reg;
        run_next     = run_reg;
        stx_next     = stx_reg;
        hinz_next    = hinz_reg;
        lo_next      = lo_reg;
        endp_next    = endp_reg;
        cs_next      = cs_reg;
        csbad_next   = csbad_reg;
        evcnt_next   = evcnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = phys_addr(head_reg, fill_reg);
        ram_wdata    = s_rx_byte;
        ram_re       = 1'b0;
        ram_raddr    = phys_addr(head_reg, j_reg);

        if (!stall) begin
            if (emit_req) begin
                evcnt_next = evcnt_reg + 1'b1;
            end
            if (fire && is_err) begin
                err_next = err_inc;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        evcnt_next = '0;
                        sp_next    = '0;
                        if (fill_reg < POS_W'(BUFFER_BYTES)) begin
                            ram_we    = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                        if (s_end_of_chunk ||
                            (fill_reg + 1'b1) >= POS_W'(BUFFER_BYTES)) begin
                            state_next = S_LOOP;
                        end
                    end
                end
                S_LOOP: begin
                    if (sp_reg >= fill_reg) begin
                        state_next = S_CMP;
                    end else begin
                        j_next     = sp_reg;
                        run_next   = '0;
                        state_next = S_FRD;
                    end
                end
                S_FRD: begin
                    if (j_reg >= fill_reg) begin
                        state_next = S_NOTF;
                    end else begin
                        ram_re     = 1'b1;
                        state_next = S_FDT;
                    end
                end
                S_FDT: begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_FRD;
                    if (ram_q == STX_BYTE) begin
                        if (run_reg == 2'd3) begin
                            stx_next   = j_reg - POS_W'(3);
                            state_next = S_FOUND;
                        end else begin
                            run_next = run_reg + 1'b1;
                        end
                    end else begin
                        run_next = '0;
                    end
                end
                S_NOTF: begin
                    if (fill_reg > POS_W'(KEEP_TAIL)) begin
                        sp_next = keep_pos;
                    end
                    state_next = S_CMP;
                end
                S_FOUND: begin
                    sp_next = stx_reg;
                    if (avail < POS_W'(HEADER_LEN)) begin
                        state_next = S_CMP;
                    end else begin
                        j_next     = stx_reg + POS_W'(4);
                        hinz_next  = 1'b0;
                        state_next = S_LRD;
                    end
                end
                S_LRD: begin
                    ram_re     = 1'b1;
                    state_next = S_LDT;
                end
                S_LDT: begin
                    if (j_reg == stx_reg + POS_W'(HEADER_LEN - 1)) begin
                        lo_next    = ram_q;
                        state_next = S_LCHK;
                    end else begin
                        hinz_next  = hinz_reg || (ram_q != 8'd0);
                        j_next     = j_reg + 1'b1;
                        state_next = S_LRD;
                    end
                end
                S_LCHK: begin
                    if (len_bad) begin
                        if (len_end > charged_reg) begin
                            charged_next = len_end;
                        end
                        sp_next    = stx_reg + 1'b1;
                        state_next = S_LOOP;
                    end else if ({1'b0, avail} < (8'd9 + lo_reg)) begin
                        state_next = S_CMP;
                    end else begin
                        j_next     = stx_reg + POS_W'(HEADER_LEN);
                        endp_next  = stx_reg + POS_W'(HEADER_LEN) + lo_reg[POS_W-1:0];
                        cs_next    = 8'd0;
                        state_next = S_CRD;
                    end
                end
                S_CRD: begin
                    ram_re     = 1'b1;
                    state_next = S_CDT;
                end
                S_CDT: begin
                    if (j_reg == endp_reg) begin
                        csbad_next = (ram_q != cs_reg);
                        state_next = S_CRES;
                    end else begin
                        cs_next    = cs_reg ^ ram_q;
                        j_next     = j_reg + 1'b1;
                        state_next = S_CRD;
                    end
                end
                S_CRES: begin
                    if (csbad_reg) begin
                        if ((endp_reg + 1'b1) > charged_reg) begin
                            charged_next = endp_reg + 1'b1;
                        end
                        sp_next    = stx_reg + 1'b1;
                        state_next = S_LOOP;
                    end else begin
                        err_next     = '0;
                        charged_next = '0;
                        j_next       = stx_reg + POS_W'(HEADER_LEN);
                        state_next   = S_PRD;
                    end
                end
                S_PRD: begin
                    ram_re     = 1'b1;
                    state_next = S_PDT;
                end
                S_PDT: begin
                    if (j_reg == endp_reg - 1'b1) begin
                        sp_next    = endp_reg + 1'b1;
                        state_next = S_LOOP;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_PRD;
                    end
                end
                S_CMP: begin
                    charged_next = (charged_reg > sp_reg) ? charged_reg - sp_reg : '0;
                    fill_next    = fill_reg - sp_reg;
                    head_next    = phys_addr(head_reg, sp_reg);
                    state_next   = S_DONE;
                end
                S_DONE: begin
                    if (room) begin
                        state_next = S_IDLE;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            charged_reg <= '0;
            err_reg     <= '0;
            evcnt_reg   <= '0;
            cfg_reg     <= LIM_W'(32);
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            charged_reg <= charged_next;
            err_reg     <= err_next;
            evcnt_reg   <= evcnt_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
        end
        sp_reg    <= sp_next;
        j_reg     <= j_next;
        run_reg   <= run_next;
        stx_reg   <= stx_next;
        hinz_reg  <= hinz_next;
        lo_reg    <= lo_next;
        endp_reg  <= endp_next;
        cs_reg    <= cs_next;
        csbad_reg <= csbad_next;
    end

endmodule

`default_nettype wire

// ----- sv/stx_length_checksum_deframer_core.sv -----
// Channel | Ports                                         | Moves
// s       | s_valid s_ready s_rx_byte s_end_of_chunk      | one received byte per request
// m       | m_valid m_ready m_event_kind m_payload_byte   | zero or more events per input
//         | m_last m_error_run_count                      |
// cfg     | cfg_wr_en cfg_wr_data                         | max payload length, no wait
//
// An input without chunk end is stored and s_ready stays high for the next byte;
// a chunk end, or a byte that fills the buffer, starts a scan of the ring
// buffer through one RAM read port (registered read): a search for four STX
// bytes, length and checksum checks per candidate frame, compaction and flush.
// Reset (synchronous, aresetn low) empties the buffer and clears the error run;
// the byte RAM itself is not cleared. A stalled m side holds the scan.
`timescale 1ns / 1ps
`default_nettype none

module stx_length_checksum_deframer_core import slcd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_rx_byte,
    input  wire logic                  s_end_of_chunk,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_event_kind,
    output logic [7:0]                 m_payload_byte,
    output logic                       m_last,
    output logic [COUNT_BITS-1:0]      m_error_run_count,
    input  wire logic                  cfg_wr_en,
    input  wire logic [LIM_W-1:0]      cfg_wr_data
);

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_q;
    logic              room;
    ostg_ctl_t         octl;

    // byte buffer, used as a ring; head advances on compaction
    slcd_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_q)
    );

    // append + frame search / length / checksum sequencer
    slcd_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_end_of_chunk(s_end_of_chunk),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_q         (ram_q),
        .room          (room),
        .octl          (octl)
    );

    // holding slot plus output register; marks last at scan end
    slcd_out_stage u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (octl),
        .room             (room),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_payload_byte   (m_payload_byte),
        .m_last           (m_last),
        .m_error_run_count(m_error_run_count)
    );

endmodule

`default_nettype wire

// ----- sv/slcd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slcd_checker import slcd_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [1:0]            m_event_kind,
    input wire logic [7:0]            m_payload_byte,
    input wire logic [COUNT_BITS-1:0] m_error_run_count
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_payload_byte))
        else $error("m request dropped or changed while stalled");

    a_pl_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == EV_PAYLOAD |-> m_error_run_count == '0)
        else $error("payload event with nonzero error run");

    a_err_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != EV_PAYLOAD |-> m_payload_byte == 8'd0)
        else $error("error event with nonzero data");

    a_err_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != EV_PAYLOAD |-> m_error_run_count != '0)
        else $error("error event with zero error run");

endmodule

bind stx_length_checksum_deframer_core slcd_checker u_slcd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_event_kind     (m_event_kind),
    .m_payload_byte   (m_payload_byte),
    .m_error_run_count(m_error_run_count)
);

`default_nettype wire
